### hw/rtl/lsfq_pkg.sv
package lsfq_pkg;

  // Default size of the requester table.
  localparam int unsigned MaxRequestersDef = 64;

  // Reset values of the configuration registers.
  localparam logic [6:0] SeatCountRst   = 7'd4;
  localparam logic [7:0] HelpLimitRst   = 8'd2;
  localparam logic [6:0] ActiveReqRst   = 7'd64;

  // Depth of the command queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SEAT_COUNT  = 2'd0,
    CFG_HELP_LIMIT  = 2'd1,
    CFG_ACTIVE_REQS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_SERVE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_SEATED   = 3'd0,
    ST_NO_SEAT  = 3'd1,
    ST_QUOTA    = 3'd2,
    ST_WAITING  = 3'd3,
    ST_ASSIGNED = 3'd4,
    ST_NONE     = 3'd5
  } status_e;

  typedef struct packed {
    logic [6:0] seat_count;
    logic [7:0] help_limit;
    logic [6:0] active;
  } cfg_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    op_e        op;
    logic [5:0] rid;
    logic       rid_ok;
    logic [7:0] sid;
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Control from the back end to the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } ctl_t;

  // One entry of the requester table.
  typedef struct packed {
    logic        waiting;
    logic [7:0]  served;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

### hw/rtl/least_served_first_waiting_queue_unit.sv
// Channel   Direction  Handshake                     Payload
// command   in         start_i, busy_o               req_type_i, requester_id_i, server_id_i
// config    in         cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
// result    out        result_valid_o (one cycle)    status_o ... all_finished_o
//
// A serve command passes the back-end states idle, scan, last and fin; an arrival adds
// an arrival check before the scan, which reads one table entry per cycle. The result
// strobe comes from a register that is loaded in the fin state. After reset a clearing
// pass zeroes the table; busy_o is high during it. Configuration writes are taken in
// every cycle, ready is always high. The result receiver cannot stall; the front queue
// holds up to two commands.
module least_served_first_waiting_queue_unit
  import lsfq_pkg::*;
#(
  parameter int unsigned MaxRequesters = MaxRequestersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [5:0]  requester_id_i,
  input  logic [7:0]  server_id_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [5:0]  chosen_requester_o,
  output logic [7:0]  assigned_server_o,
  output logic [7:0]  chosen_priority_o,
  output logic [6:0]  seats_taken_o,
  output logic [31:0] total_requests_o,
  output logic [31:0] total_sessions_o,
  output logic        all_finished_o
);

  cfg_t  cfg_q, cfg_d;
  head_t head;
  ctl_t  ctl;

  // Configuration registers. A write to an index beyond the list is dropped.
  // Software is to write only while the block is idle; the block does not enforce it and has no shadowing.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SEAT_COUNT:  cfg_d.seat_count = cfg_data_i[6:0];
        CFG_HELP_LIMIT:  cfg_d.help_limit = cfg_data_i;
        CFG_ACTIVE_REQS: cfg_d.active     = cfg_data_i[6:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seat_count <= SeatCountRst;
      cfg_q.help_limit <= HelpLimitRst;
      cfg_q.active     <= ActiveReqRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each command transaction and queues it, so a new
  // command can be taken while the back end is still scanning the table.
  lsfq_front #(
    .MaxRequesters (MaxRequesters)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_type_i     (req_type_i),
    .requester_id_i (requester_id_i),
    .server_id_i    (server_id_i),
    .ctl_i          (ctl),
    .busy_o         (busy_o),
    .head_o         (head)
  );

  // The back end owns the requester table and the counters. Each command ends
  // with a full pass over the table, which both picks the least served waiting
  // requester and recounts the finished requesters.
  lsfq_back #(
    .MaxRequesters (MaxRequesters)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .head_i             (head),
    .ctl_o              (ctl),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .chosen_requester_o (chosen_requester_o),
    .assigned_server_o  (assigned_server_o),
    .chosen_priority_o  (chosen_priority_o),
    .seats_taken_o      (seats_taken_o),
    .total_requests_o   (total_requests_o),
    .total_sessions_o   (total_sessions_o),
    .all_finished_o     (all_finished_o)
  );

endmodule

### hw/rtl/lsfq_ram.sv
module lsfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lsfq_front.sv
module lsfq_front
  import lsfq_pkg::*;
#(
  parameter int unsigned MaxRequesters = MaxRequestersDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       req_type_i,
  input  logic [5:0] requester_id_i,
  input  logic [7:0] server_id_i,
  input  ctl_t       ctl_i,
  output logic       busy_o,
  output head_t      head_o
);

  localparam int unsigned IdxW = $clog2(MaxRequesters);
  localparam int unsigned CmpW = (IdxW + 1 > 7) ? IdxW + 1 : 7;

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QueuePtrW:0]   fill_q, fill_d;
  logic                 full, push;
  cmd_t                 cmd_in;

  // Classify the incoming command; a requester beyond the table is flagged here.
  always_comb begin
    cmd_in.op     = op_e'(req_type_i);
    cmd_in.rid    = requester_id_i;
    cmd_in.rid_ok = (CmpW'(requester_id_i) < CmpW'(MaxRequesters));
    cmd_in.sid    = server_id_i;
  end

  assign full   = (fill_q == (QueuePtrW + 1)'(QueueDepth));
  assign busy_o = full || ctl_i.clearing;
  assign push   = start_i && !busy_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = (wptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (ctl_i.pop) begin
      rptr_d = (rptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !ctl_i.pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!push && ctl_i.pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = slot_q[rptr_q];

endmodule

### hw/rtl/lsfq_back.sv
module lsfq_back
  import lsfq_pkg::*;
#(
  parameter int unsigned MaxRequesters = MaxRequestersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  head_t       head_i,
  output ctl_t        ctl_o,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [5:0]  chosen_requester_o,
  output logic [7:0]  assigned_server_o,
  output logic [7:0]  chosen_priority_o,
  output logic [6:0]  seats_taken_o,
  output logic [31:0] total_requests_o,
  output logic [31:0] total_sessions_o,
  output logic        all_finished_o
);

  localparam int unsigned IdxW = $clog2(MaxRequesters);
  localparam int unsigned CmpW = (IdxW + 1 > 7) ? IdxW + 1 : 7;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxRequesters - 1);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_ARR_CHK = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_LAST    = 7'b0010000,
    S_FIN     = 7'b0100000,
    S_SPARE   = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [7:0]      best_s_q, best_s_d;
  logic [31:0]     best_t_q, best_t_d;
  logic [IdxW:0]   fin_q, fin_d;
  logic [6:0]      occ_q, occ_d;
  logic [31:0]     req_q, req_d;
  logic [31:0]     sess_q, sess_d;
  status_e         arr_st_q, arr_st_d;

  logic            res_valid_q, res_valid_d;
  status_e         res_st_q, res_st_d;
  logic [5:0]      res_chosen_q, res_chosen_d;
  logic [7:0]      res_server_q, res_server_d;
  logic [7:0]      res_prio_q, res_prio_d;
  logic            res_fin_q, res_fin_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  entry_t            rd_e, wr_e;

  logic [31:0]     req_inc, sess_inc;
  logic [7:0]      new_s;
  logic            corr;
  logic [IdxW:0]   fin_total;
  logic [6:0]      fin_sat;
  logic [CmpW-1:0] lim;

  lsfq_ram #(
    .Width (EntryW),
    .Depth (MaxRequesters)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_e      = entry_t'(ram_rdata);
  assign ram_wdata = EntryW'(wr_e);

  assign req_inc  = (req_q == '1) ? req_q : req_q + 1'b1;
  assign sess_inc = (sess_q == '1) ? sess_q : sess_q + 1'b1;
  assign new_s    = (best_s_q == 8'hFF) ? best_s_q : best_s_q + 1'b1;

  // The scan counts finished requesters on the old counts; the served entry
  // may cross the limit in this step and is added here.
  assign corr = found_q && (cmd_q.op == OP_SERVE) &&
                (CmpW'(best_idx_q) < CmpW'(cfg_i.active)) &&
                (best_s_q < cfg_i.help_limit) && (new_s >= cfg_i.help_limit);
  assign fin_total = fin_q + (IdxW + 1)'(corr);
  assign fin_sat   = (fin_total > (IdxW + 1)'(127)) ? 7'd127 : 7'(fin_total);
  assign lim       = (CmpW'(cfg_i.active) < CmpW'(MaxRequesters)) ?
                     CmpW'(cfg_i.active) : CmpW'(MaxRequesters);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    pv_d         = (state_q == S_SCAN);
    idx_d        = cnt_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_s_d     = best_s_q;
    best_t_d     = best_t_q;
    fin_d        = fin_q;
    occ_d        = occ_q;
    req_d        = req_q;
    sess_d       = sess_q;
    arr_st_d     = arr_st_q;
    res_valid_d  = 1'b0;
    res_st_d     = res_st_q;
    res_chosen_d = res_chosen_q;
    res_server_d = res_server_q;
    res_prio_d   = res_prio_q;
    res_fin_d    = res_fin_q;
    ram_we       = 1'b0;
    ram_waddr    = IdxW'(cmd_q.rid);
    ram_raddr    = cnt_q;
    wr_e         = '0;
    ctl_o.pop      = 1'b0;
    ctl_o.clearing = (state_q == S_CLEAR);

    // Entry read in the previous cycle during the scan: lexicographic minimum of
    // (served, stamp), lowest index on full ties, plus the finished count.
    if (pv_q) begin
      if (rd_e.waiting && (!found_q || (rd_e.served < best_s_q) ||
          ((rd_e.served == best_s_q) && (rd_e.stamp < best_t_q)))) begin
        found_d    = 1'b1;
        best_idx_d = idx_q;
        best_s_d   = rd_e.served;
        best_t_d   = rd_e.stamp;
      end
      if ((CmpW'(idx_q) < CmpW'(cfg_i.active)) && (rd_e.served >= cfg_i.help_limit)) begin
        fin_d = fin_q + 1'b1;
      end
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = IdxW'(head_i.cmd.rid);
        if (head_i.valid) begin
          ctl_o.pop = 1'b1;
          cmd_d     = head_i.cmd;
          cnt_d     = '0;
          found_d   = 1'b0;
          fin_d     = '0;
          state_d   = (head_i.cmd.op == OP_ARRIVE) ? S_ARR_CHK : S_SCAN;
        end
      end
      S_ARR_CHK: begin
        state_d = S_SCAN;
        if (!cmd_q.rid_ok || (rd_e.served >= cfg_i.help_limit)) begin
          arr_st_d = ST_QUOTA;
        end else if (occ_q >= cfg_i.seat_count) begin
          arr_st_d = ST_NO_SEAT;
        end else if (rd_e.waiting) begin
          arr_st_d = ST_WAITING;
        end else begin
          arr_st_d     = ST_SEATED;
          occ_d        = occ_q + 1'b1;
          req_d        = req_inc;
          ram_we       = 1'b1;
          wr_e.waiting = 1'b1;
          wr_e.served  = rd_e.served;
          wr_e.stamp   = req_inc;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d      = S_IDLE;
        res_valid_d  = 1'b1;
        res_chosen_d = '0;
        res_server_d = '0;
        res_prio_d   = '0;
        res_st_d     = arr_st_q;
        if (cmd_q.op == OP_SERVE) begin
          if (found_q) begin
            res_st_d     = ST_ASSIGNED;
            res_chosen_d = 6'(best_idx_q);
            res_server_d = cmd_q.sid;
            res_prio_d   = best_s_q;
            occ_d        = (occ_q != '0) ? occ_q - 1'b1 : occ_q;
            sess_d       = sess_inc;
            ram_we       = 1'b1;
            ram_waddr    = best_idx_q;
            wr_e.waiting = 1'b0;
            wr_e.served  = new_s;
            wr_e.stamp   = best_t_q;
          end else begin
            res_st_d = ST_NONE;
          end
        end
        res_fin_d = (CmpW'(fin_sat) >= lim);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      fin_q       <= '0;
      occ_q       <= '0;
      req_q       <= '0;
      sess_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      fin_q       <= fin_d;
      occ_q       <= occ_d;
      req_q       <= req_d;
      sess_q      <= sess_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    best_idx_q   <= best_idx_d;
    best_s_q     <= best_s_d;
    best_t_q     <= best_t_d;
    arr_st_q     <= arr_st_d;
    res_st_q     <= res_st_d;
    res_chosen_q <= res_chosen_d;
    res_server_q <= res_server_d;
    res_prio_q   <= res_prio_d;
    res_fin_q    <= res_fin_d;
  end

  assign result_valid_o     = res_valid_q;
  assign status_o           = res_st_q;
  assign chosen_requester_o = res_chosen_q;
  assign assigned_server_o  = res_server_q;
  assign chosen_priority_o  = res_prio_q;
  assign seats_taken_o      = occ_q;
  assign total_requests_o   = req_q;
  assign total_sessions_o   = sess_q;
  assign all_finished_o     = res_fin_q;

  // The table is never written while the scan is reading it.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("table written during scan");

  // A result strobe follows the final step of a command.
  a_result_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == S_FIN))
    else $error("result strobe without a finished command");

  // The session counter only moves when a waiting requester was found.
  a_sess_on_assign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sess_q != $past(sess_q)) |-> $past((state_q == S_FIN) && found_q))
    else $error("session counted without an assignment");

  // Occupancy only grows when an arrival is checked.
  a_occ_grows_on_arrival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q > $past(occ_q)) |-> $past(state_q == S_ARR_CHK))
    else $error("seat taken outside an arrival");

endmodule
